>>> design/box_downsample_rgba16_core_defines.svh
// assertion macros shared by the box downsample design files
`ifndef BOX_DOWNSAMPLE_RGBA16_CORE_DEFINES_SVH
`define BOX_DOWNSAMPLE_RGBA16_CORE_DEFINES_SVH

// invariant checked at every clock edge outside reset
`define BDR16_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define BDR16_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BDR16_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bdr16_pkg.sv
// types, constants and division tables for the box downsample block
`default_nettype none

package bdr16_pkg;

    localparam int MAX_OUT_WIDTH  = 4096;
    localparam int MAX_OUT_HEIGHT = 4096;
    localparam int MAX_FACTOR     = 4;

    localparam int COL_W    = $clog2(MAX_OUT_WIDTH);
    localparam int ROW_W    = $clog2(MAX_OUT_HEIGHT);
    localparam int SUB_W    = $clog2(MAX_FACTOR);
    localparam int FACTOR_W = 3;
    localparam int DIM_W    = 13;
    localparam int CHAN_W   = 16;
    localparam int SUM_W    = CHAN_W + $clog2(MAX_FACTOR * MAX_FACTOR);
    localparam int RECIP_W  = 18;
    localparam int SHIFT_W  = 5;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = CMDQ_PTR_W + 1;

    typedef enum logic [1:0] {
        REG_SCALE  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] alpha_in;
    } sample_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_avg;
        logic [CHAN_W-1:0] green_avg;
        logic [CHAN_W-1:0] blue_avg;
        logic [CHAN_W-1:0] alpha_avg;
        logic              frame_end;
    } pixel_t;

    // one classified sample on its way from the front to the back
    typedef struct packed {
        sample_t          smp;
        logic [COL_W-1:0] col;
        logic             first;
        logic             last;
        logic             frame_end;
    } cmd_t;

    typedef logic [3:0][SUM_W-1:0] ch_sum_t;

    typedef struct packed {
        logic [SUM_W-1:0]   half;
        logic [RECIP_W-1:0] recip;
        logic [SHIFT_W-1:0] shift;
    } div_t;

    // (sum + half) / (f*f) == ((sum + half) * recip) >> shift for every block sum
    function automatic div_t div_consts(logic [FACTOR_W-1:0] f);
        div_t d;
        d.half  = '0;
        d.recip = RECIP_W'(1);
        d.shift = '0;
        case (f)
            3'd2:
            begin
                d.half  = SUM_W'(2);
                d.shift = SHIFT_W'(2);
            end
            3'd3:
            begin
                d.half  = SUM_W'(4);
                d.recip = RECIP_W'(233017);
                d.shift = SHIFT_W'(21);
            end
            3'd4:
            begin
                d.half  = SUM_W'(8);
                d.shift = SHIFT_W'(4);
            end
            default:
            begin
                d.half  = '0;
            end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

>>> design/bdr16_front.sv
// front end: configuration registers, position counters and sample classification
`default_nettype none
`include "box_downsample_rgba16_core_defines.svh"

module bdr16_front
    import bdr16_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic      [DATA_W-1:0]   prdata,
    input  wire logic                push,
    input  wire sample_t             sample,
    input  wire logic                q_full,
    output logic                     q_push,
    output cmd_t                     q_cmd,
    output logic      [FACTOR_W-1:0] factor
);

    logic [FACTOR_W-1:0] scale_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;

    logic [SUB_W-1:0] sub_col_reg, sub_col_next;
    logic [SUB_W-1:0] sub_row_reg, sub_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
    logic [SUB_W-1:0] last_sub;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic             cfg_wr;
    logic             cfg_hit;

    // effective geometry after clamping the registers
    always_comb
    begin
        if (scale_reg == '0)
            factor = FACTOR_W'(1);
        else if (scale_reg > FACTOR_W'(MAX_FACTOR))
            factor = FACTOR_W'(MAX_FACTOR);
        else
            factor = scale_reg;

        if (width_reg == '0)
            eff_w = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_OUT_WIDTH))
            eff_w = DIM_W'(MAX_OUT_WIDTH);
        else
            eff_w = width_reg;

        if (height_reg == '0)
            eff_h = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_OUT_HEIGHT))
            eff_h = DIM_W'(MAX_OUT_HEIGHT);
        else
            eff_h = height_reg;

        last_sub = SUB_W'(factor - FACTOR_W'(1));
        last_col = COL_W'(eff_w - DIM_W'(1));
        last_row = ROW_W'(eff_h - DIM_W'(1));
    end

    assign cfg_wr = psel && penable && pwrite;
    assign cfg_hit = cfg_wr && (paddr[3:2] == REG_SCALE || paddr[3:2] == REG_WIDTH
                                || paddr[3:2] == REG_HEIGHT);

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_SCALE:  prdata = DATA_W'(scale_reg);
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= FACTOR_W'(1);
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_SCALE:  scale_reg  <= pwdata[FACTOR_W-1:0];
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:    scale_reg  <= scale_reg;
            endcase
        end
    end

    assign q_push = push && !q_full;

    always_comb
    begin
        q_cmd.smp       = sample;
        q_cmd.col       = out_col_reg;
        q_cmd.first     = (sub_col_reg == '0) && (sub_row_reg == '0);
        q_cmd.last      = (sub_col_reg == last_sub) && (sub_row_reg == last_sub);
        q_cmd.frame_end = q_cmd.last && (out_col_reg == last_col)
                          && (out_row_reg == last_row);
    end

    // raster walk: sample column, output column, sample row, output row
    always_comb
    begin
        sub_col_next = sub_col_reg;
        sub_row_next = sub_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_hit)
        begin
            sub_col_next = '0;
            sub_row_next = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (q_push)
        begin
            if (sub_col_reg != last_sub)
                sub_col_next = sub_col_reg + SUB_W'(1);
            else
            begin
                sub_col_next = '0;
                if (out_col_reg != last_col)
                    out_col_next = out_col_reg + COL_W'(1);
                else
                begin
                    out_col_next = '0;
                    if (sub_row_reg != last_sub)
                        sub_row_next = sub_row_reg + SUB_W'(1);
                    else
                    begin
                        sub_row_next = '0;
                        if (out_row_reg != last_row)
                            out_row_next = out_row_reg + ROW_W'(1);
                        else
                            out_row_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            sub_col_reg <= sub_col_next;
            sub_row_reg <= sub_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    `BDR16_ASSERT_ALWAYS(a_sub_in_block, (sub_col_reg <= last_sub) && (sub_row_reg <= last_sub), "sub position outside block")
    `BDR16_ASSERT_ALWAYS(a_pos_in_frame, (out_col_reg <= last_col) && (out_row_reg <= last_row), "output position outside frame")

endmodule

`default_nettype wire

>>> design/bdr16_cmdq.sv
// short command queue between the front and back ends
`default_nettype none
`include "box_downsample_rgba16_core_defines.svh"

module bdr16_cmdq
    import bdr16_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t din,
    output logic      full,
    input  wire logic pop,
    output cmd_t      dout,
    output logic      empty
);

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] cnt_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + CMDQ_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + CMDQ_PTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + CMDQ_CNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - CMDQ_CNT_W'(1);
        end
    end

    `BDR16_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CMDQ_CNT_W'(CMDQ_DEPTH), "queue count overflow")
    `BDR16_ASSERT_NEXT(a_cnt_grow, do_push && !do_pop, cnt_reg == $past(cnt_reg) + CMDQ_CNT_W'(1), "queue count did not grow")

endmodule

`default_nettype wire

>>> design/bdr16_back.sv
// back end: column sum line store, rounding divide and result register
`default_nettype none
`include "box_downsample_rgba16_core_defines.svh"

module bdr16_back
    import bdr16_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [FACTOR_W-1:0] factor,
    input  wire cmd_t                q_cmd,
    input  wire logic                q_empty,
    output logic                     q_pop,
    output pixel_t                   result,
    output logic                     empty,
    input  wire logic                pop
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADD  = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [4*SUM_W-1:0] mem [MAX_OUT_WIDTH];

    cmd_t                   cmd_reg;
    ch_sum_t                rd_reg;
    ch_sum_t                rnd_reg;
    logic [3:0][PROD_W-1:0] prod_reg;
    logic [SHIFT_W-1:0]     shift_reg;
    pixel_t                 out_reg;
    logic                   out_valid_reg;

    logic [3:0][CHAN_W-1:0] smp_ch;
    ch_sum_t                sum_new;
    logic [3:0][CHAN_W-1:0] quot;
    div_t                   dc;
    logic                   out_load;

    assign dc       = div_consts(factor);
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || pop);

    always_comb
    begin
        smp_ch = {cmd_reg.smp.red_in, cmd_reg.smp.green_in,
                  cmd_reg.smp.blue_in, cmd_reg.smp.alpha_in};
        for (int c = 0; c < 4; c++)
        begin
            // the first sample of a block overwrites the stale entry
            if (cmd_reg.first)
                sum_new[c] = SUM_W'(smp_ch[c]);
            else
                sum_new[c] = rd_reg[c] + SUM_W'(smp_ch[c]);
            quot[c] = CHAN_W'(prod_reg[c] >> shift_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                if (cmd_reg.last)
                    state_next = S_DIV;
                else
                    state_next = S_IDLE;
            end
            S_DIV:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // line store: read issued on dequeue, written back in the add state
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADD)
            mem[cmd_reg.col] <= sum_new;
        rd_reg <= mem[q_cmd.col];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_cmd;
        if (state_reg == S_ADD)
        begin
            for (int c = 0; c < 4; c++)
                rnd_reg[c] <= sum_new[c] + dc.half;
        end
        if (state_reg == S_DIV)
        begin
            for (int c = 0; c < 4; c++)
                prod_reg[c] <= {{RECIP_W{1'b0}}, rnd_reg[c]} * {{SUM_W{1'b0}}, dc.recip};
            shift_reg <= dc.shift;
        end
        if (out_load)
        begin
            out_reg.red_avg   <= quot[3];
            out_reg.green_avg <= quot[2];
            out_reg.blue_avg  <= quot[1];
            out_reg.alpha_avg <= quot[0];
            out_reg.frame_end <= cmd_reg.frame_end;
        end
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

    `BDR16_ASSERT_IMP(a_emit_on_last, state_reg == S_EMIT, cmd_reg.last, "result for a sample that does not close a block")

endmodule

`default_nettype wire

>>> design/box_downsample_rgba16_core.sv
// top level of the box filter supersample resolve block
//
// Input items (RGBA16 samples, premultiplied linear) enter in raster order of
// the high-resolution frame through a queue-style port: an item is taken on a
// clock edge with push high and full low. Each factor-by-factor block of
// samples yields one averaged pixel item, offered on result while empty is low
// and taken on an edge with pop high. frame_end marks the last pixel of a frame.
// The APB port sets the scale factor (0x0), the output line width (0x4) and the
// output frame height (0x8); any register write restarts the frame position.
// Write only while idle.
// A four-entry queue decouples item intake from the line-store update.
// The back end reads the line store on dequeue, then adds and writes back;
// an item that closes a block goes on to the multiply and the output load,
// where it waits while the result register is still full. Items are taken
// one at a time: the next is dequeued only once the last is through. Empty
// goes low once the closing item has passed the queue and these steps.
// When pop stays low the result register holds, the back end waits, the queue
// fills, and full rises. Reset empties the queue and result register, sets
// all registers to 1 and restarts at the top-left of a frame; no clearing pass.
`default_nettype none

module box_downsample_rgba16_core
    import bdr16_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              push,
    output logic                   full,
    input  wire sample_t           sample,
    output logic                   empty,
    input  wire logic              pop,
    output pixel_t                 result
);

    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    cmd_t                q_in;
    cmd_t                q_out;
    logic [FACTOR_W-1:0] factor;

    assign pready = 1'b1;
    assign full   = q_full;

    bdr16_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .push    (push),
        .sample  (sample),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_in),
        .factor  (factor)
    );

    bdr16_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty)
    );

    bdr16_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .factor  (factor),
        .q_cmd   (q_out),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

`default_nettype wire

>>> sim/bdr16_resolve_check.sv
// watches the box downsample block, predicts each averaged pixel and compares
`timescale 1ns / 1ps
`default_nettype none

module bdr16_resolve_check
    import bdr16_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    input  wire logic [DATA_W-1:0] prdata,
    input  wire logic              pready,
    input  wire logic              push,
    input  wire logic              full,
    input  wire sample_t           sample,
    input  wire logic              empty,
    input  wire logic              pop,
    input  wire pixel_t            result,
    output int                     errors,
    output int                     pending,
    output int                     pixels_seen
);

    logic [FACTOR_W-1:0] factor_q;
    logic [DIM_W-1:0]    width_q;
    logic [DIM_W-1:0]    height_q;

    int unsigned sub_x;
    int unsigned blk_x;
    int unsigned sub_y;
    int unsigned blk_y;

    logic [SUM_W-1:0] line_acc [MAX_OUT_WIDTH][4];
    pixel_t           pixel_q [$];
    pixel_t           want;
    int               err_cnt;
    int               pix_cnt;
    logic [DATA_W-1:0] read_want;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [CHAN_W-1:0] block_mean(logic [SUM_W-1:0] acc, int unsigned d);
        int unsigned q;
        q = (int'(acc) + d / 2) / d;
        return q[CHAN_W-1:0];
    endfunction

    task automatic report(string what, int unsigned got, int unsigned exp_val);
        $display("resolve_check: %s mismatch, got %0h want %0h at %0t", what, got, exp_val,
                 $realtime);
        err_cnt++;
    endtask

    // accumulate one sample into its column and queue the pixel if the block closes
    task automatic predict_sample(sample_t s);
        int unsigned      f;
        int unsigned      w;
        int unsigned      h;
        int unsigned      d;
        logic [CHAN_W-1:0] ch [4];
        pixel_t           p;
        f = clamp_dim(factor_q, MAX_FACTOR);
        w = clamp_dim(width_q, MAX_OUT_WIDTH);
        h = clamp_dim(height_q, MAX_OUT_HEIGHT);
        if (sub_x >= f) sub_x = 0;
        if (sub_y >= f) sub_y = 0;
        if (blk_x >= w) blk_x = 0;
        if (blk_y >= h) blk_y = 0;
        ch = '{s.red_in, s.green_in, s.blue_in, s.alpha_in};
        for (int c = 0; c < 4; c++)
        begin
            if (sub_x == 0 && sub_y == 0)
                line_acc[blk_x][c] = SUM_W'(ch[c]);
            else
                line_acc[blk_x][c] = line_acc[blk_x][c] + SUM_W'(ch[c]);
        end
        if (sub_x == f - 1 && sub_y == f - 1)
        begin
            d = f * f;
            p.red_avg   = block_mean(line_acc[blk_x][0], d);
            p.green_avg = block_mean(line_acc[blk_x][1], d);
            p.blue_avg  = block_mean(line_acc[blk_x][2], d);
            p.alpha_avg = block_mean(line_acc[blk_x][3], d);
            p.frame_end = (blk_x == w - 1) && (blk_y == h - 1);
            pixel_q.push_back(p);
        end
        sub_x++;
        if (sub_x >= f)
        begin
            sub_x = 0;
            blk_x++;
            if (blk_x >= w)
            begin
                blk_x = 0;
                sub_y++;
                if (sub_y >= f)
                begin
                    sub_y = 0;
                    blk_y++;
                    if (blk_y >= h) blk_y = 0;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_q = FACTOR_W'(1);
            width_q  = DIM_W'(1);
            height_q = DIM_W'(1);
            sub_x    = 0;
            blk_x    = 0;
            sub_y    = 0;
            blk_y    = 0;
            pixel_q.delete();
        end
        else
        begin
            if (psel && penable && pready && pwrite)
            begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_SCALE:  factor_q = pwdata[FACTOR_W-1:0];
                    REG_WIDTH:  width_q  = pwdata[DIM_W-1:0];
                    REG_HEIGHT: height_q = pwdata[DIM_W-1:0];
                    default:    ;
                endcase
                // any valid register restarts the frame position
                if (paddr[ADDR_W-1:2] inside {REG_SCALE, REG_WIDTH, REG_HEIGHT})
                begin
                    sub_x = 0;
                    blk_x = 0;
                    sub_y = 0;
                    blk_y = 0;
                end
            end
            if (psel && penable && pready && !pwrite)
            begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_SCALE:  read_want = DATA_W'(factor_q);
                    REG_WIDTH:  read_want = DATA_W'(width_q);
                    REG_HEIGHT: read_want = DATA_W'(height_q);
                    default:    read_want = prdata;
                endcase
                if (prdata !== read_want)
                    report("register read", prdata, read_want);
            end
            if (pop && !empty)
            begin
                if (pixel_q.size() == 0)
                    report("unexpected pixel", 32'(result.red_avg), 0);
                else
                begin
                    want = pixel_q.pop_front();
                    pix_cnt++;
                    if (result.red_avg !== want.red_avg)
                        report("red_avg", 32'(result.red_avg), 32'(want.red_avg));
                    if (result.green_avg !== want.green_avg)
                        report("green_avg", 32'(result.green_avg), 32'(want.green_avg));
                    if (result.blue_avg !== want.blue_avg)
                        report("blue_avg", 32'(result.blue_avg), 32'(want.blue_avg));
                    if (result.alpha_avg !== want.alpha_avg)
                        report("alpha_avg", 32'(result.alpha_avg), 32'(want.alpha_avg));
                    if (result.frame_end !== want.frame_end)
                        report("frame_end", 32'(result.frame_end), 32'(want.frame_end));
                end
            end
            if (push && !full)
                predict_sample(sample);
        end
        errors      <= err_cnt;
        pending     <= pixel_q.size();
        pixels_seen <= pix_cnt;
    end

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// testbench top: drives samples, pops and register writes for the box downsample block
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import bdr16_pkg::*;

    localparam int REG_SPARE = 3;

    logic              clk;
    logic              rst_n   = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              push    = 1'b0;
    logic              full;
    sample_t           sample  = '0;
    logic              empty;
    logic              pop     = 1'b0;
    pixel_t            result;

    int errors;
    int pending;
    int pixels_seen;

    int unsigned n_sent;
    int unsigned n_settings;
    bit          push_calm;
    bit          pop_calm;
    int          pop_hold;

    box_downsample_rgba16_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .full    (full),
        .sample  (sample),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    bdr16_resolve_check resolve_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .sample      (sample),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .errors      (errors),
        .pending     (pending),
        .pixels_seen (pixels_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(30_000_000);
        $display("tb_top: done, errors");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver: stalls at random, calm stretches now and then
    always @(posedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end
        else
        begin
            pop      <= 1'b1;
            pop_hold <= pick_gap(pop_calm);
        end
        if ($urandom_range(0, 299) == 0)
            pop_calm <= !pop_calm;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    function automatic sample_t mk_sample(int r, int g, int b, int a);
        sample_t s;
        s.red_in   = CHAN_W'(r);
        s.green_in = CHAN_W'(g);
        s.blue_in  = CHAN_W'(b);
        s.alpha_in = CHAN_W'(a);
        return s;
    endfunction

    task automatic push_sample(sample_t s);
        int gap;
        push   <= 1'b1;
        sample <= s;
        do @(posedge clk); while (full);
        n_sent++;
        gap = pick_gap(push_calm);
        if ($urandom_range(0, 149) == 0)
            push_calm = !push_calm;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic push_random(int unsigned count);
        repeat (count) push_sample(mk_sample(rand_chan(), rand_chan(), rand_chan(),
                                             rand_chan()));
    endtask

    // stop sending and let every expected pixel come out, then the tail of the pipe
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic reg_access(int idx, bit wr, logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(int unsigned f, int unsigned w, int unsigned h);
        int unsigned vals [3];
        int          first;
        int          idx;
        vals  = '{f, w, h};
        first = $urandom_range(0, 2);
        settle();
        for (int k = 0; k < 3; k++)
        begin
            idx = (first + k) % 3;
            reg_access(idx, 1'b1, DATA_W'(vals[idx]));
        end
        if ($urandom_range(0, 4) == 0)
            reg_access(REG_SPARE, 1'b1, $urandom);
        reg_access(REG_SCALE, 1'b0, '0);
        reg_access(REG_WIDTH, 1'b0, '0);
        reg_access(REG_HEIGHT, 1'b0, '0);
        n_settings++;
    endtask

    initial
    begin
        int unsigned f;
        int unsigned w;
        int unsigned h;
        int unsigned len;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers come out of reset at 1
        reg_access(REG_SCALE, 1'b0, '0);
        reg_access(REG_WIDTH, 1'b0, '0);
        reg_access(REG_HEIGHT, 1'b0, '0);

        // factor 1, one pixel per frame: straight copies
        push_sample(mk_sample(0, 0, 0, 0));
        push_sample(mk_sample(16'hffff, 16'hffff, 16'hffff, 16'hffff));
        push_sample(mk_sample(16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
        push_sample(mk_sample(16'h5555, 16'haaaa, 16'h5555, 16'haaaa));

        // factor 2: rounding at exact halves and below
        settle();
        reg_access(REG_SCALE, 1'b1, 2);
        push_sample(mk_sample(16'hffff, 0, 0, 3));
        push_sample(mk_sample(16'hffff, 0, 0, 3));
        push_sample(mk_sample(16'hffff, 0, 0, 0));
        push_sample(mk_sample(16'hffff, 2, 1, 0));

        // factor 4 at full scale, a write to the spare index mid-block changes nothing
        settle();
        reg_access(REG_SCALE, 1'b1, 4);
        repeat (8) push_sample(mk_sample(16'hffff, 16'hffff, 16'hffff, 16'hffff));
        settle();
        reg_access(REG_SPARE, 1'b1, 32'h0000_0003);
        repeat (8) push_sample(mk_sample(16'hffff, 16'hffff, 16'hffff, 16'hffff));

        // factor 0 acts as 1, width saturates to the line store size, height 0 acts as 1
        configure(0, 8191, 0);
        push_random(64);

        while (n_sent < 1400)
        begin
            case ($urandom_range(0, 9))
                0:       f = 0;
                1:       f = $urandom_range(5, 7);
                default: f = $urandom_range(1, 4);
            endcase
            case ($urandom_range(0, 19))
                0:       w = 0;
                1:       w = $urandom_range(MAX_OUT_WIDTH, 8191);
                default: w = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 19))
                0:       h = 0;
                1:       h = $urandom_range(MAX_OUT_HEIGHT, 8191);
                default: h = $urandom_range(1, 4);
            endcase
            configure(f, w, h);
            len = clamp_dim(f, MAX_FACTOR) ** 2 * clamp_dim(w, MAX_OUT_WIDTH)
                  * clamp_dim(h, MAX_OUT_HEIGHT);
            if (len <= 400)
            begin
                repeat ($urandom_range(1, 2))
                begin
                    push_random(len);
                    if ($urandom_range(0, 9) == 0)
                        settle();
                end
                // broken frame, cut off by the next register write
                if ($urandom_range(0, 3) == 0)
                    push_random($urandom_range(1, len));
            end
            else
                push_random($urandom_range(1, 300));
        end

        settle();
        $display("tb_top: %0d samples over %0d register settings, %0d pixels compared",
                 n_sent, n_settings, pixels_seen);
        $display("tb_top: factors 0..7, widths and heights 0..8191, frame wraps and cut frames");
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+design
design/bdr16_pkg.sv
design/bdr16_front.sv
design/bdr16_cmdq.sv
design/bdr16_back.sv
design/box_downsample_rgba16_core.sv
sim/bdr16_resolve_check.sv
sim/tb_top.sv
